@@ rtl/dcr_pkg.sv @@
`timescale 1ns / 1ps

package dcr_pkg;

    localparam int DEPTH_BITS_DEF = 24;

    // configuration register map
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_DEPTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAR_DEPTH  = 2'd1;

    localparam int NEAR_DEPTH_RESET = 768;
    localparam int FAR_DEPTH_RESET  = 15360;

    // the ramp spans ten scale steps
    localparam int BAND_STEPS = 10;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // ramp quotient stays below 3 * 255, so ten bits
    localparam int QUO_BITS = 10;

    localparam int               COLOR_BITS = 8;
    localparam logic [COLOR_BITS-1:0] COLOR_FULL = 8'hff;
    localparam logic [COLOR_BITS-1:0] COLOR_NONE = 8'h00;

    typedef enum logic [2:0] {
        BAND_BELOW,
        BAND_GREEN_UP,
        BAND_BLUE_DOWN,
        BAND_RED_UP,
        BAND_GREEN_DOWN,
        BAND_BLUE_UP,
        BAND_ABOVE
    } t_band;

    typedef struct packed {
        logic  valid;
        t_band band;
    } t_cell_ctrl;

endpackage

@@ rtl/depth_to_color_ramp.sv @@
`timescale 1ns / 1ps

// Depth to color ramp: maps each signed fixed-point depth sample to a jet-style
// RGB color between the near and far bounds. One sample is taken per clock while
// o_in_stall is low. The pipeline holds five front stages (offset, band select, ramp
// numerator), a chain of ten divider cells that each resolve one quotient bit of
// offset*255/step, the color stage and the output register. Throughput is one
// sample per clock, limited by nothing but the output stall; a two-entry output
// stage absorbs a stall so the input stall is registered. After a configuration
// write the derived step settles through the difference, scale and multiple
// registers ahead of the samples that use it, so samples may follow a write on
// the next clock.
module depth_to_color_ramp import dcr_pkg::*; #(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [DEPTH_BITS-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DEPTH_BITS-1:0] i_depth,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [COLOR_BITS-1:0]        o_red,
    output logic [COLOR_BITS-1:0]        o_green,
    output logic [COLOR_BITS-1:0]        o_blue
);

    localparam int SW = DEPTH_BITS - 3;
    localparam int RW = DEPTH_BITS + 8;
    localparam int QW = QUO_BITS;

    localparam logic signed [DEPTH_BITS-1:0] NEAR_RST = DEPTH_BITS'(NEAR_DEPTH_RESET);
    localparam logic signed [DEPTH_BITS-1:0] FAR_RST  = DEPTH_BITS'(FAR_DEPTH_RESET);

    // configuration
    logic signed [DEPTH_BITS-1:0] r_near, n_near;
    logic signed [DEPTH_BITS-1:0] r_far, n_far;

    always_comb begin
        n_near = r_near;
        n_far  = r_far;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NEAR_DEPTH: n_near = i_cfg_data;
                REG_FAR_DEPTH:  n_far  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
            r_far  <= FAR_RST;
        end else begin
            r_near <= n_near;
            r_far  <= n_far;
        end
    end

    logic [SW-1:0]         w_scale;
    logic [DEPTH_BITS-1:0] w_mul1, w_mul2, w_mul4, w_mul7, w_mul10;

    dcr_scale #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_near  (r_near),
        .i_far   (r_far),
        .o_scale (w_scale),
        .o_mul2  (w_mul2),
        .o_mul4  (w_mul4),
        .o_mul7  (w_mul7),
        .o_mul10 (w_mul10)
    );

    assign w_mul1 = DEPTH_BITS'(w_scale);

    // the whole pipeline moves unless the skid entry is holding a result
    logic r_skid_valid, n_skid_valid;
    logic w_adv;

    assign w_adv      = ~r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // stage 1: input transfer
    logic                         r_s1_valid;
    logic signed [DEPTH_BITS-1:0] r_s1_depth;

    // stage 2: offset from the near bound
    logic                         r_s2_valid;
    logic signed [DEPTH_BITS:0]   r_s2_off;
    logic signed [DEPTH_BITS:0]   n_s2_off;

    // stage 3: below flag and unsigned offset
    logic                  r_s3_valid;
    logic                  r_s3_below;
    logic [DEPTH_BITS-1:0] r_s3_off;

    // stage 4: band and offset into the band
    t_cell_ctrl            r_s4_ctrl, n_s4_ctrl;
    logic [DEPTH_BITS-1:0] r_s4_rel, n_s4_rel;
    logic [DEPTH_BITS-1:0] w_start;

    // stage 5: ramp numerator rel * 255
    t_cell_ctrl            r_s5_ctrl;
    logic [RW-1:0]         r_s5_num, n_s5_num;

    assign n_s2_off = {r_s1_depth[DEPTH_BITS-1], r_s1_depth}
                    - {r_near[DEPTH_BITS-1], r_near};

    always_comb begin
        n_s4_ctrl.valid = r_s3_valid;
        w_start         = '0;
        if (r_s3_below) begin
            n_s4_ctrl.band = BAND_BELOW;
        end else if (r_s3_off < w_mul1) begin
            n_s4_ctrl.band = BAND_GREEN_UP;
        end else if (r_s3_off < w_mul2) begin
            n_s4_ctrl.band = BAND_BLUE_DOWN;
            w_start        = w_mul1;
        end else if (r_s3_off < w_mul4) begin
            n_s4_ctrl.band = BAND_RED_UP;
            w_start        = w_mul2;
        end else if (r_s3_off < w_mul7) begin
            n_s4_ctrl.band = BAND_GREEN_DOWN;
            w_start        = w_mul4;
        end else if (r_s3_off < w_mul10) begin
            n_s4_ctrl.band = BAND_BLUE_UP;
            w_start        = w_mul7;
        end else begin
            n_s4_ctrl.band = BAND_ABOVE;
        end
        n_s4_rel = r_s3_off - w_start;
    end

    assign n_s5_num = {r_s4_rel, 8'b0} - RW'(r_s4_rel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_ctrl  <= '{valid: 1'b0, band: BAND_BELOW};
            r_s5_ctrl  <= '{valid: 1'b0, band: BAND_BELOW};
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_ctrl  <= n_s4_ctrl;
            r_s5_ctrl  <= r_s4_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_depth <= i_depth;
            r_s2_off   <= n_s2_off;
            r_s3_below <= r_s2_off[DEPTH_BITS];
            r_s3_off   <= r_s2_off[DEPTH_BITS-1:0];
            r_s4_rel   <= n_s4_rel;
            r_s5_num   <= n_s5_num;
        end
    end

    // divider chain, most significant quotient bit first
    t_cell_ctrl    w_ctrl [0:QW];
    logic [RW-1:0] w_rem  [0:QW];
    logic [QW-1:0] w_quo  [0:QW];

    assign w_ctrl[0] = r_s5_ctrl;
    assign w_rem[0]  = r_s5_num;
    assign w_quo[0]  = '0;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        dcr_div_cell #(
            .DEPTH_BITS(DEPTH_BITS),
            .SHIFT     (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctrl  (w_ctrl[k]),
            .i_rem   (w_rem[k]),
            .i_quo   (w_quo[k]),
            .i_scale (w_scale),
            .o_ctrl  (w_ctrl[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quo   (w_quo[k+1])
        );
    end

    // color stage
    logic                  r_col_valid;
    logic [COLOR_BITS-1:0] r_col_red, r_col_green, r_col_blue;
    logic [COLOR_BITS-1:0] n_col_red, n_col_green, n_col_blue;
    logic [COLOR_BITS-1:0] w_ramp;

    // only the low byte of the quotient is kept, so wide bands wrap
    assign w_ramp = w_quo[QW][COLOR_BITS-1:0];

    always_comb begin
        n_col_red   = COLOR_NONE;
        n_col_green = COLOR_NONE;
        n_col_blue  = COLOR_NONE;
        case (w_ctrl[QW].band)
            BAND_BELOW: begin
                n_col_blue = COLOR_FULL;
            end
            BAND_GREEN_UP: begin
                n_col_green = w_ramp;
                n_col_blue  = COLOR_FULL;
            end
            BAND_BLUE_DOWN: begin
                n_col_green = COLOR_FULL;
                n_col_blue  = ~w_ramp;
            end
            BAND_RED_UP: begin
                n_col_red   = w_ramp;
                n_col_green = COLOR_FULL;
            end
            BAND_GREEN_DOWN: begin
                n_col_red   = COLOR_FULL;
                n_col_green = ~w_ramp;
            end
            BAND_BLUE_UP: begin
                n_col_red  = COLOR_FULL;
                n_col_blue = w_ramp;
            end
            default: begin
                n_col_red  = COLOR_FULL;
                n_col_blue = COLOR_FULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_valid <= 1'b0;
        end else if (w_adv) begin
            r_col_valid <= w_ctrl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col_red   <= n_col_red;
            r_col_green <= n_col_green;
            r_col_blue  <= n_col_blue;
        end
    end

    // output register with one skid entry behind it
    logic                  r_out_valid, n_out_valid;
    logic [COLOR_BITS-1:0] r_out_red, r_out_green, r_out_blue;
    logic [COLOR_BITS-1:0] r_skid_red, r_skid_green, r_skid_blue;
    logic                  w_out_take;
    logic                  w_load_out_col, w_load_out_skid, w_load_skid;

    assign w_out_take = r_out_valid & ~i_out_stall;

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_out_col  = 1'b0;
        w_load_out_skid = 1'b0;
        w_load_skid     = 1'b0;
        if (r_skid_valid) begin
            if (w_out_take) begin
                w_load_out_skid = 1'b1;
                n_skid_valid    = 1'b0;
            end
        end else if (r_col_valid) begin
            if (!r_out_valid || w_out_take) begin
                w_load_out_col = 1'b1;
                n_out_valid    = 1'b1;
            end else begin
                w_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out_col) begin
            r_out_red   <= r_col_red;
            r_out_green <= r_col_green;
            r_out_blue  <= r_col_blue;
        end else if (w_load_out_skid) begin
            r_out_red   <= r_skid_red;
            r_out_green <= r_skid_green;
            r_out_blue  <= r_skid_blue;
        end
        if (w_load_skid) begin
            r_skid_red   <= r_col_red;
            r_skid_green <= r_col_green;
            r_skid_blue  <= r_col_blue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall && r_col_valid))
        else $error("skid entry filled without a stalled output");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> ($stable(r_s5_ctrl) && $stable(r_col_valid)
                          && $stable(r_s1_valid)))
        else $error("pipeline moved while the skid entry was full");

endmodule

@@ rtl/dcr_scale.sv @@
`timescale 1ns / 1ps

module dcr_scale import dcr_pkg::*; #(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [DEPTH_BITS-1:0] i_near,
    input  logic signed [DEPTH_BITS-1:0] i_far,
    output logic        [DEPTH_BITS-4:0] o_scale,
    output logic        [DEPTH_BITS-1:0] o_mul2,
    output logic        [DEPTH_BITS-1:0] o_mul4,
    output logic        [DEPTH_BITS-1:0] o_mul7,
    output logic        [DEPTH_BITS-1:0] o_mul10
);

    localparam int SW = DEPTH_BITS - 3;
    localparam int PW = DEPTH_BITS + 32;

    localparam logic signed [DEPTH_BITS-1:0] NEAR_RST = DEPTH_BITS'(NEAR_DEPTH_RESET);
    localparam logic signed [DEPTH_BITS-1:0] FAR_RST  = DEPTH_BITS'(FAR_DEPTH_RESET);
    localparam logic signed [DEPTH_BITS:0]   DIFF_RST =
        (DEPTH_BITS+1)'(FAR_RST) - (DEPTH_BITS+1)'(NEAR_RST);
    localparam logic [SW-1:0] SCALE_RST =
        (DIFF_RST < BAND_STEPS) ? '0 : SW'(DIFF_RST / BAND_STEPS);
    localparam logic [DEPTH_BITS-1:0] MUL2_RST  = DEPTH_BITS'(SCALE_RST * 2);
    localparam logic [DEPTH_BITS-1:0] MUL4_RST  = DEPTH_BITS'(SCALE_RST * 4);
    localparam logic [DEPTH_BITS-1:0] MUL7_RST  = DEPTH_BITS'(SCALE_RST * 7);
    localparam logic [DEPTH_BITS-1:0] MUL10_RST = DEPTH_BITS'(SCALE_RST * 10);

    logic signed [DEPTH_BITS:0]   r_diff, n_diff;
    logic        [SW-1:0]         r_scale, n_scale;
    logic        [DEPTH_BITS-1:0] r_mul2, r_mul4, r_mul7, r_mul10;
    logic        [DEPTH_BITS-1:0] n_mul2, n_mul4, n_mul7, n_mul10;
    logic        [DEPTH_BITS-1:0] w_mag;
    logic        [DEPTH_BITS-1:0] w_s;
    logic        [PW-1:0]         w_prod;

    assign n_diff = {i_far[DEPTH_BITS-1], i_far} - {i_near[DEPTH_BITS-1], i_near};

    // a negative span behaves like a zero step: nothing lands in a band
    assign w_mag   = r_diff[DEPTH_BITS] ? '0 : r_diff[DEPTH_BITS-1:0];
    assign w_prod  = PW'(w_mag) * PW'(DIV10_RECIP);
    assign n_scale = w_prod[DIV10_SHIFT +: SW];

    assign w_s     = DEPTH_BITS'(r_scale);
    assign n_mul2  = w_s << 1;
    assign n_mul4  = w_s << 2;
    assign n_mul7  = (w_s << 3) - w_s;
    assign n_mul10 = (w_s << 3) + (w_s << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff  <= DIFF_RST;
            r_scale <= SCALE_RST;
            r_mul2  <= MUL2_RST;
            r_mul4  <= MUL4_RST;
            r_mul7  <= MUL7_RST;
            r_mul10 <= MUL10_RST;
        end else begin
            r_diff  <= n_diff;
            r_scale <= n_scale;
            r_mul2  <= n_mul2;
            r_mul4  <= n_mul4;
            r_mul7  <= n_mul7;
            r_mul10 <= n_mul10;
        end
    end

    assign o_scale = r_scale;
    assign o_mul2  = r_mul2;
    assign o_mul4  = r_mul4;
    assign o_mul7  = r_mul7;
    assign o_mul10 = r_mul10;

endmodule

@@ rtl/dcr_div_cell.sv @@
`timescale 1ns / 1ps

module dcr_div_cell import dcr_pkg::*; #(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int SHIFT      = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  t_cell_ctrl                i_ctrl,
    input  logic [DEPTH_BITS+7:0]     i_rem,
    input  logic [QUO_BITS-1:0]       i_quo,
    input  logic [DEPTH_BITS-4:0]     i_scale,
    output t_cell_ctrl                o_ctrl,
    output logic [DEPTH_BITS+7:0]     o_rem,
    output logic [QUO_BITS-1:0]       o_quo
);

    localparam int RW = DEPTH_BITS + 8;

    t_cell_ctrl      r_ctrl;
    logic [RW-1:0]   r_rem;
    logic [QUO_BITS-1:0] r_quo;
    logic [RW-1:0]   w_div;
    logic [RW:0]     w_trial;

    // restoring step: subtract the shifted divisor if it fits
    assign w_div   = RW'(i_scale) << SHIFT;
    assign w_trial = {1'b0, i_rem} - {1'b0, w_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '{valid: 1'b0, band: BAND_BELOW};
        end else if (i_adv) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= w_trial[RW] ? i_rem : w_trial[RW-1:0];
            r_quo <= {i_quo[QUO_BITS-2:0], ~w_trial[RW]};
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench import dcr_pkg::*; ();

    localparam int DEPTH_BITS = DEPTH_BITS_DEF;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    // register indexes that map to nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_3 = 2'd3;

    // band starts, in scale steps from the near bound
    localparam int RAMP_EDGES [6] = '{0, 1, 2, 4, 7, 10};

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_rgb;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]      i_cfg_index = '0;
    logic [DEPTH_BITS-1:0]        i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic signed [DEPTH_BITS-1:0] i_depth = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [COLOR_BITS-1:0]        o_red;
    logic [COLOR_BITS-1:0]        o_green;
    logic [COLOR_BITS-1:0]        o_blue;

    logic signed [DEPTH_BITS-1:0] near_bound;
    logic signed [DEPTH_BITS-1:0] far_bound;
    t_rgb                         pending_colors [$];
    int                           mismatch_count = 0;
    int                           tx_idle_pct = 0;
    int                           rx_idle_pct = 0;
    int                           rx_hold_cycles = 0;

    depth_to_color_ramp #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_depth    (i_depth),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [COLOR_BITS-1:0] ramp_level(input longint offset,
                                                         input longint step);
        longint q;
        q = (offset * 255) / step;
        return q[COLOR_BITS-1:0];
    endfunction

    // a zero or negative step leaves no band open, so everything at or above near is magenta
    function automatic t_rgb ramp_color(input logic signed [DEPTH_BITS-1:0] depth);
        longint lo;
        longint d;
        longint step;
        t_band  band;
        t_rgb   c;
        lo = longint'(near_bound);
        d = longint'(depth);
        step = (longint'(far_bound) - lo) / BAND_STEPS;
        if (d < lo) begin
            band = BAND_BELOW;
        end else if (d < lo + step) begin
            band = BAND_GREEN_UP;
        end else if (d < lo + 2 * step) begin
            band = BAND_BLUE_DOWN;
        end else if (d < lo + 4 * step) begin
            band = BAND_RED_UP;
        end else if (d < lo + 7 * step) begin
            band = BAND_GREEN_DOWN;
        end else if (d < lo + BAND_STEPS * step) begin
            band = BAND_BLUE_UP;
        end else begin
            band = BAND_ABOVE;
        end
        case (band)
            BAND_BELOW: begin
                c = '{COLOR_NONE, COLOR_NONE, COLOR_FULL};
            end
            BAND_GREEN_UP: begin
                c = '{COLOR_NONE, ramp_level(d - lo, step), COLOR_FULL};
            end
            BAND_BLUE_DOWN: begin
                c = '{COLOR_NONE, COLOR_FULL, COLOR_FULL - ramp_level(d - lo - step, step)};
            end
            BAND_RED_UP: begin
                c = '{ramp_level(d - lo - 2 * step, step), COLOR_FULL, COLOR_NONE};
            end
            BAND_GREEN_DOWN: begin
                c = '{COLOR_FULL, COLOR_FULL - ramp_level(d - lo - 4 * step, step), COLOR_NONE};
            end
            BAND_BLUE_UP: begin
                c = '{COLOR_FULL, COLOR_NONE, ramp_level(d - lo - 7 * step, step)};
            end
            default: begin
                c = '{COLOR_FULL, COLOR_NONE, COLOR_FULL};
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [DEPTH_BITS-1:0] to_depth(input longint v);
        if (v > longint'(DEPTH_MAX)) begin
            return DEPTH_MAX;
        end else if (v < longint'(DEPTH_MIN)) begin
            return DEPTH_MIN;
        end
        return v[DEPTH_BITS-1:0];
    endfunction

    // mostly depths inside the ramp or right at a band edge, some anywhere
    function automatic longint next_depth();
        logic signed [DEPTH_BITS-1:0] raw;
        longint lo;
        longint step;
        int     pick;
        lo = longint'(near_bound);
        step = (longint'(far_bound) - lo) / BAND_STEPS;
        pick = $urandom_range(99);
        if (pick < 10) begin
            raw = DEPTH_BITS'($urandom);
            return longint'(raw);
        end else if (pick < 30) begin
            return lo + RAMP_EDGES[$urandom_range(5)] * step + int'($urandom_range(4)) - 2;
        end else if (step > 0) begin
            return lo - step + longint'($urandom_range(0, int'(12 * step)));
        end
        return lo + int'($urandom_range(40)) - 20;
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_colors
        t_rgb want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_colors.size() == 0) begin
                mismatch_count++;
                $display("%0t: color transfer with none expected, expected none actual %0d %0d %0d",
                         $time, o_red, o_green, o_blue);
            end else begin
                want = pending_colors.pop_front();
                if (o_red !== want.red) begin
                    mismatch_count++;
                    $display("%0t: red expected %0d actual %0d", $time, want.red, o_red);
                end
                if (o_green !== want.green) begin
                    mismatch_count++;
                    $display("%0t: green expected %0d actual %0d", $time, want.green, o_green);
                end
                if (o_blue !== want.blue) begin
                    mismatch_count++;
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, o_blue);
                end
            end
        end
    end

    // all tasks below start and end just after a rising edge
    task automatic send_depth(input logic signed [DEPTH_BITS-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_depth <= d;
        do @(posedge i_clk); while (o_in_stall);
        pending_colors = {pending_colors, ramp_color(d)};
    endtask

    task automatic wait_for_colors();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_colors.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [DEPTH_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_NEAR_DEPTH: near_bound = data;
            REG_FAR_DEPTH:  far_bound = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_bounds(input longint near_v, input longint far_v);
        wait_for_colors();
        write_reg(REG_NEAR_DEPTH, to_depth(near_v));
        write_reg(REG_FAR_DEPTH, to_depth(far_v));
    endtask

    task automatic set_idling(input int tx, input int rx);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        @(posedge i_clk);
    endtask

    task automatic test_reset_ramp();
        longint step;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        near_bound = DEPTH_BITS'(NEAR_DEPTH_RESET);
        far_bound = DEPTH_BITS'(FAR_DEPTH_RESET);
        @(posedge i_clk);
        step = (longint'(far_bound) - near_bound) / BAND_STEPS;
        // both sides of every band edge on the power-up ramp
        send_depth(DEPTH_MIN);
        foreach (RAMP_EDGES[k]) begin
            send_depth(to_depth(near_bound + RAMP_EDGES[k] * step - 1));
            send_depth(to_depth(near_bound + RAMP_EDGES[k] * step));
        end
        send_depth(DEPTH_MAX);
    endtask

    task automatic test_unmapped_index();
        logic [DEPTH_BITS-1:0] junk;
        wait_for_colors();
        junk = DEPTH_BITS'($urandom);
        write_reg(REG_UNMAPPED_2, junk);
        junk = DEPTH_BITS'($urandom);
        write_reg(REG_UNMAPPED_3, junk);
        send_depth(near_bound);
        send_depth(to_depth(near_bound + 5 * ((longint'(far_bound) - near_bound) / BAND_STEPS)));
    endtask

    task automatic test_degenerate_scale();
        // span under ten units: zero step
        set_bounds(1000, 1009);
        send_depth(999);
        send_depth(1000);
        send_depth(DEPTH_MAX);
        // far below near: negative step
        set_bounds(2000, -3000);
        send_depth(1999);
        send_depth(2000);
    endtask

    task automatic test_full_span();
        set_bounds(DEPTH_MIN, DEPTH_MAX);
        send_depth(DEPTH_MIN);
        send_depth(DEPTH_MAX);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        wait_for_colors();
        @(negedge i_clk);
        rx_hold_cycles = 250;
        @(posedge i_clk);
        // the pipeline fills during the hold and must stall its input
        repeat (80) send_depth(to_depth(next_depth()));
        wait_for_colors();
    endtask

    task automatic program_random_bounds();
        logic signed [DEPTH_BITS-1:0] raw_near;
        logic signed [DEPTH_BITS-1:0] raw_far;
        longint near_v;
        longint far_v;
        int     kind;
        kind = $urandom_range(9);
        if (kind < 4) begin
            near_v = int'($urandom_range(4000)) - 2000;
            far_v = near_v + $urandom_range(10, 30000);
        end else if (kind == 4) begin
            near_v = int'($urandom_range(60000)) - 30000;
            far_v = near_v + $urandom_range(25);
        end else if (kind == 5) begin
            near_v = int'($urandom_range(100000)) - 50000;
            far_v = near_v - $urandom_range(1, 50000);
            if ($urandom_range(3) == 0) begin
                near_v = DEPTH_MAX;
                far_v = DEPTH_MIN;
            end
        end else if (kind == 6) begin
            near_v = ($urandom_range(1) == 0) ? longint'(DEPTH_MIN)
                                              : -longint'($urandom_range(1, 1 << 22));
            far_v = DEPTH_MAX;
        end else if (kind == 7) begin
            raw_near = DEPTH_BITS'($urandom);
            raw_far = DEPTH_BITS'($urandom);
            near_v = longint'(raw_near);
            far_v = longint'(raw_far);
        end else begin
            near_v = -longint'($urandom_range(1, 1 << (DEPTH_BITS - 1)));
            far_v = $urandom_range(0, (1 << (DEPTH_BITS - 1)) - 1);
        end
        set_bounds(near_v, far_v);
    endtask

    task automatic test_random_stream(input int tx, input int rx);
        set_idling(tx, rx);
        repeat (6) begin
            program_random_bounds();
            repeat (100) send_depth(to_depth(next_depth()));
        end
    endtask

    initial begin
        set_idling(26, 87);
        test_reset_ramp();
        test_unmapped_index();
        test_degenerate_scale();
        test_full_span();
        test_backpressure();
        test_random_stream(26, 87);
        test_random_stream(87, 26);
        test_random_stream(0, 0);
        wait_for_colors();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_colors.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
